// ----- hw/rtl/isb_pkg.sv -----
// Shared constants and types for the byte insertion sorter.
`default_nettype none

package isb_pkg;

   localparam int MAX_LEN = 64;
   localparam int BYTE_W  = 8;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   // What one cell tells its neighbors.
   typedef struct packed {
      logic              valid;
      logic              gt;
      logic [BYTE_W-1:0] value;
   } link_type;

   // Cell control broadcast from the sequencer.
   typedef struct packed {
      logic              insert;
      logic              shift;
      logic [BYTE_W-1:0] data;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- hw/rtl/isb_cell.sv -----
// One cell of the sorting chain: holds a byte and trades it with its neighbors.
`default_nettype none

module isb_cell
   import isb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire link_type      left,
   input  wire link_type      right,
   output link_type           link
);

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] value_ff;
   logic [BYTE_W-1:0] value_in;
   logic              gt;
   logic              take;

   // Equal bytes do not count as greater, so a new byte lands after them.
   assign gt   = valid_ff && (value_ff > ctrl.data);
   assign take = ctrl.insert && (gt || (!valid_ff && left.valid));

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = right.value;
         valid_in = right.valid;
      end else if (take) begin
         value_in = left.gt ? left.value : ctrl.data;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign link.valid = valid_ff;
   assign link.gt    = gt;
   assign link.value = value_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/insertion_sort_bytes.sv -----
// Stable byte sorter: a chain of cells with a drain sequencer and output register.
//
// Input stream (req_): one byte per beat, req_tlast on the final byte of a run.
// While collecting, one byte is accepted every cycle; each byte is compared
// against every cell at once and slotted in after any equal bytes.
// Up to MAX_LEN bytes are held; further bytes of the run are dropped and the
// run is flagged as overflowed. A dropped final byte still ends the run.
// After the final byte is accepted the chain shifts toward cell zero, one
// byte per cycle while the receiver does not stall, into the output register.
// Accepting the final input beat registers the drain state; each shift then
// loads the output register, which drives rsp_tvalid. req_tready is low
// while the run drains, so a new run is taken only once the chain is empty.
// Result stream (rsp_): bytes in ascending order, rsp_tlast on the final one,
// rsp_tuser[0] set on every beat of an overflowed run.
// When the receiver stalls, the output register holds its beat and the chain
// does not shift. The next run may start while the final beat still waits.
// Reset empties the chain and returns to collecting; no clearing pass.
`default_nettype none

module insertion_sort_bytes
   import isb_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [BYTE_W-1:0] req_tdata,   // [7:0] data_byte
   input  wire logic              req_tlast,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [BYTE_W-1:0]      rsp_tdata,   // [7:0] sorted_byte
   output logic                   rsp_tlast,
   output logic [0:0]             rsp_tuser    // [0] overflow
);

   localparam link_type HEAD_LINK = '{valid: 1'b1, gt: 1'b0, value: '0};
   localparam link_type TAIL_LINK = '{valid: 1'b0, gt: 1'b0, value: '0};

   state_type         state_ff;
   state_type         state_in;
   logic              ovf_ff;
   logic              ovf_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [BYTE_W-1:0] rsp_data_ff;
   logic              rsp_last_ff;
   logic              rsp_ovf_ff;
   logic              accept;
   logic              full;
   logic              shift;
   cell_ctrl_type     ctrl;
   link_type          links [MAX_LEN];
   logic [MAX_LEN-1:0] valid_vec;

   assign full   = links[MAX_LEN-1].valid;
   assign accept = req_tvalid && req_tready;
   assign shift  = (state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_tready);

   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = shift;
   assign ctrl.data   = req_tdata;

   for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
      if (i == 0) begin : g_first
         isb_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .left  (HEAD_LINK),
            .right (links[i+1]),
            .link  (links[i])
         );
      end else if (i == MAX_LEN - 1) begin : g_last
         isb_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .left  (links[i-1]),
            .right (TAIL_LINK),
            .link  (links[i])
         );
      end else begin : g_mid
         isb_cell u_cell (
            .clock (clock),
            .reset (reset),
            .ctrl  (ctrl),
            .left  (links[i-1]),
            .right (links[i+1]),
            .link  (links[i])
         );
      end
      assign valid_vec[i] = links[i].valid;
   end

   always_comb begin
      state_in     = state_ff;
      ovf_in       = ovf_ff;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_COLLECT: begin
            req_tready = 1'b1;
            if (accept) begin
               ovf_in = ovf_ff | full;
               if (req_tlast) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (shift) begin
               rsp_valid_in = 1'b1;
               // Cell one empty means cell zero holds the final byte.
               if (!links[1].valid) begin
                  state_in = ST_COLLECT;
                  ovf_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_COLLECT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         rsp_data_ff <= links[0].value;
         rsp_last_ff <= !links[1].valid;
         rsp_ovf_ff  <= ovf_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tlast    = rsp_last_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

   // Occupied cells always form an unbroken run starting at cell zero.
   a_contiguous: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + MAX_LEN'(1)) & valid_vec) == '0)
      else $error("chain occupancy has a gap");

   a_drain_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> links[0].valid)
      else $error("draining an empty chain");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      (shift && !links[1].valid) |=> (state_ff == ST_COLLECT) && !links[0].valid
         && rsp_tvalid && rsp_tlast)
      else $error("drain did not end cleanly");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      (ovf_ff && (state_ff == ST_COLLECT)) |-> full)
      else $error("overflow flagged with room left");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the stable byte insertion sorter.
`timescale 1ns / 1ps

typedef struct packed {
   logic [7:0] sorted_byte;
   logic       last_out;
   logic       overflow;
} sorted_beat_type;

typedef enum int {
   SPREAD_ANY,
   SPREAD_NARROW,
   SPREAD_EXTREMES
} spread_type;

class sorted_run_scoreboard;
   logic [7:0]      held_bytes[$];
   logic            bytes_dropped = 1'b0;
   sorted_beat_type sorted_beats_due[$];
   int              mismatches    = 0;
   int              bytes_in      = 0;
   int              runs_done     = 0;
   int              overflow_runs = 0;
   int              beats_checked = 0;

   // A new byte goes after every held byte that is not greater than it.
   function void insert_stable(logic [7:0] value);
      int pos;
      pos = held_bytes.size();
      while (pos > 0 && held_bytes[pos-1] > value)
         pos--;
      held_bytes.insert(pos, value);
   endfunction

   function void note_input(logic [7:0] data_byte, logic is_final);
      sorted_beat_type beat;
      bytes_in++;
      if (held_bytes.size() < isb_pkg::MAX_LEN)
         insert_stable(data_byte);
      else
         bytes_dropped = 1'b1;
      if (is_final) begin
         runs_done++;
         if (bytes_dropped)
            overflow_runs++;
         foreach (held_bytes[k]) begin
            beat.sorted_byte = held_bytes[k];
            beat.last_out    = (k == held_bytes.size() - 1);
            beat.overflow    = bytes_dropped;
            sorted_beats_due.push_back(beat);
         end
         held_bytes.delete();
         bytes_dropped = 1'b0;
      end
   endfunction

   function int pending();
      return sorted_beats_due.size();
   endfunction

   task report(string msg);
      mismatches++;
      // Keep the log short when the block is badly broken.
      if (mismatches <= 50)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task check_result(logic [7:0] sorted_byte, logic last_out, logic overflow);
      sorted_beat_type due;
      beats_checked++;
      if (sorted_beats_due.size() == 0) begin
         report($sformatf("unexpected beat, byte %02h", sorted_byte));
         return;
      end
      due = sorted_beats_due.pop_front();
      if (sorted_byte !== due.sorted_byte)
         report($sformatf("sorted_byte %02h, expected %02h", sorted_byte, due.sorted_byte));
      if (last_out !== due.last_out)
         report($sformatf("last_out %b, expected %b (byte %02h)",
                          last_out, due.last_out, due.sorted_byte));
      if (overflow !== due.overflow)
         report($sformatf("overflow %b, expected %b (byte %02h)",
                          overflow, due.overflow, due.sorted_byte));
   endtask
endclass

module tb;
   import isb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_ITEMS = 370;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [BYTE_W-1:0] req_tdata  = '0;   // [7:0] data_byte
   logic              req_tlast  = 1'b0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [BYTE_W-1:0] rsp_tdata;         // [7:0] sorted_byte
   logic              rsp_tlast;
   logic [0:0]        rsp_tuser;         // [0] overflow

   logic steady_mode = 1'b0;
   int   rsp_stall   = 0;
   int   cycle_count = 0;

   sorted_run_scoreboard sb = new;

   // Directed runs, {last, byte}: single minimum, single maximum, a mixed run
   // with ties and both extremes, a rising run that walks every bit, a falling run.
   logic [8:0] directed_beats [23] = '{
      9'h100,
      9'h1FF,
      9'h0FF, 9'h000, 9'h080, 9'h007, 9'h007, 9'h000, 9'h0FF, 9'h101,
      9'h001, 9'h002, 9'h004, 9'h008, 9'h010, 9'h020, 9'h040, 9'h180,
      9'h0FE, 9'h0AA, 9'h07F, 9'h055, 9'h101
   };

   insertion_sort_bytes DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Watchdog expired after %0d cycles.", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Both handshakes are sampled with their values from before the edge.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_input(req_tdata, req_tlast);
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tlast, rsp_tuser[0]);
   end

   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady_mode && $urandom_range(0, 3) == 0)
            rsp_stall <= pick_gap();
      end
   end

   task automatic send_byte(logic [7:0] value, logic is_final);
      int gap;
      gap = 0;
      if (!steady_mode && $urandom_range(0, 2) == 0)
         gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_final;
      do @(posedge clock); while (!req_tready);
   endtask

   // The extra edge lets the monitor post the results of the final beat first.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   function automatic logic [7:0] next_byte(spread_type spread, logic [7:0] base);
      case (spread)
         SPREAD_ANY:    return 8'($urandom_range(0, 255));
         SPREAD_NARROW: return base + 8'($urandom_range(0, 3));
         default:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
   endfunction

   task automatic send_random_run(int length);
      spread_type spread;
      logic [7:0] base;
      spread = spread_type'($urandom_range(0, 2));
      base   = 8'($urandom_range(0, 255));
      for (int i = 0; i < length; i++)
         send_byte(next_byte(spread, base), i == length - 1);
   endtask

   initial begin : stimulus
      int run_count;
      int length;
      run_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_beats[k])
         send_byte(directed_beats[k][7:0], directed_beats[k][8]);
      wait_drained();

      // The first runs fill the store exactly, then drop the final byte, then
      // drop several; after that most runs are short and a few run near or past the limit.
      while (sb.bytes_in < TARGET_ITEMS) begin
         case (run_count)
            0:       length = MAX_LEN;
            1:       length = MAX_LEN + 1;
            2:       length = MAX_LEN + 6;
            default: length = ($urandom_range(0, 19) == 0) ?
                              $urandom_range(MAX_LEN - 4, MAX_LEN + 8) :
                              $urandom_range(1, 12);
         endcase
         steady_mode <= ($urandom_range(0, 4) == 0);
         send_random_run(length);
         run_count++;
         if (run_count == 6)
            wait_drained();
      end

      wait_drained();
      repeat (20) @(posedge clock);

      $display("Sorted %0d runs (%0d with dropped bytes) from %0d input bytes;",
               sb.runs_done, sb.overflow_runs, sb.bytes_in);
      $display("%0d result beats compared, %0d mismatches.", sb.beats_checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

// ----- insertion_sort_bytes.f -----
hw/rtl/isb_pkg.sv
hw/rtl/isb_cell.sv
hw/rtl/insertion_sort_bytes.sv
tb/tb.sv
